// ===== sv/si_window_detector_defines.svh =====
// Assertion macros for the checker of si_window_detector.
// Depends on nothing; the including module must have clock and reset in scope.
`ifndef SI_WINDOW_DETECTOR_DEFINES_SVH
`define SI_WINDOW_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SIWD_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("si_window_detector: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SIWD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("si_window_detector: next-cycle check failed");

`endif

// ===== sv/siwd_pkg.sv =====
// Shared types and constants of the SI window detector.
// Used by every module of the block; depends on nothing.
`default_nettype none

package siwd_pkg;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2
   } opcode_type;

   localparam int OPCODE_W = 2;
   localparam int LIST_W = 5;
   localparam int PERIOD_W = 10;
   localparam int FRAME_W = 10;
   localparam int SF_W = 4;
   localparam int WINDOW_W = 6;
   localparam int START_W = 11;
   localparam int TTI_W = 14;
   localparam int SUBFRAMES_PER_FRAME = 10;

endpackage

`default_nettype wire

// ===== sv/siwd_table.sv =====
// Schedule entry memory: one write port and one registered read port.
// Depends on siwd_pkg for the entry field widths.
`default_nettype none

module siwd_table #(
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [AW-1:0]                  wr_addr,
   input  wire logic [siwd_pkg::PERIOD_W-1:0]  wr_period,
   input  wire logic [siwd_pkg::START_W-1:0]   wr_start,
   input  wire logic                           rd_en,
   input  wire logic [AW-1:0]                  rd_addr,
   output logic      [siwd_pkg::PERIOD_W-1:0]  rd_period,
   output logic      [siwd_pkg::START_W-1:0]   rd_start
);
   import siwd_pkg::*;

   logic [PERIOD_W-1:0] period_mem [DEPTH];
   logic [START_W-1:0]  start_mem  [DEPTH];
   logic [PERIOD_W-1:0] rd_period_ff;
   logic [START_W-1:0]  rd_start_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         period_mem[wr_addr] <= wr_period;
         start_mem[wr_addr]  <= wr_start;
      end
      if (rd_en) begin
         rd_period_ff <= period_mem[rd_addr];
         rd_start_ff  <= start_mem[rd_addr];
      end
   end

   assign rd_period = rd_period_ff;
   assign rd_start  = rd_start_ff;

endmodule

`default_nettype wire

// ===== sv/siwd_mod_unit.sv =====
// Shared restoring remainder unit, one dividend bit per cycle.
// Depends on siwd_pkg for the operand width.
`default_nettype none

module siwd_mod_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [siwd_pkg::TTI_W-1:0]  dividend,
   input  wire logic [siwd_pkg::TTI_W-1:0]  divisor,
   output logic                             done,
   output logic      [siwd_pkg::TTI_W-1:0]  remainder
);
   import siwd_pkg::*;

   localparam int CNT_W = $clog2(TTI_W);

   logic [TTI_W-1:0] rem_ff, rem_in;
   logic [TTI_W-1:0] dvd_ff, dvd_in;
   logic [TTI_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [TTI_W:0]   trial;

   always_comb begin
      trial   = {rem_ff, dvd_ff[TTI_W-1]};
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         dvd_in = dividend;
         div_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = TTI_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[TTI_W-1:0];
         end
         dvd_in = {dvd_ff[TTI_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(TTI_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== sv/si_window_detector.sv =====
// SI window detector top level: command port, window register and entry walk.
// Depends on siwd_pkg, siwd_table and siwd_mod_unit.
//
// A transaction is taken when start is high and busy is low; its result appears
// on the rsp_ ports for exactly one cycle with rsp_valid high, and the receiver
// cannot stall it. Clear and append answer in the cycle after they are taken, as
// does a query that finds an empty table or a subframe of 10 or more. Any other
// query walks the stored entries in order through one shared serial remainder
// unit: each entry takes a memory read, a load, 14 remainder steps and the
// compare, and the walk stops at the first hit; busy stays high until it ends and
// the result appears as busy falls. The user must write the window register
// (csr_wr_en) only while busy is low; the block itself does not enforce this.
`default_nettype none

module si_window_detector #(
   parameter int MAX_ENTRIES = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [siwd_pkg::OPCODE_W-1:0]  req_opcode,
   input  wire logic [siwd_pkg::LIST_W-1:0]    req_list_index,
   input  wire logic [siwd_pkg::PERIOD_W-1:0]  req_period_frames,
   input  wire logic [siwd_pkg::FRAME_W-1:0]   req_frame_number,
   input  wire logic [siwd_pkg::SF_W-1:0]      req_subframe,
   output logic                                rsp_valid,
   output logic                                rsp_in_window,
   output logic                                rsp_entry_stored,
   input  wire logic                           csr_wr_en,
   input  wire logic [siwd_pkg::WINDOW_W-1:0]  csr_wr_data
);
   import siwd_pkg::*;

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_DIV
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [WINDOW_W-1:0]  window_ff, window_in;
   logic [TTI_W-1:0]     tti_ff, tti_in;
   logic [START_W-1:0]   start_ff, start_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 hit_ff, hit_in;
   logic                 stored_ff, stored_in;

   logic                 accept;
   logic                 wr_en;
   logic [START_W-1:0]   wr_start;
   logic                 rd_en;
   logic [PERIOD_W-1:0]  rd_period;
   logic [START_W-1:0]   rd_start;
   logic                 mod_start;
   logic [TTI_W-1:0]     mod_divisor;
   logic                 mod_done;
   logic [TTI_W-1:0]     mod_rem;
   logic                 pos_hit;
   logic                 last_entry;

   assign accept   = start && (state_ff == ST_IDLE);
   assign wr_start = START_W'(req_list_index) * START_W'(window_ff);
   assign wr_en    = accept && (req_opcode == OP_APPEND) && (req_period_frames != '0)
                     && (window_ff != '0) && (count_ff < CNT_W'(MAX_ENTRIES));
   assign rd_en    = (state_ff == ST_READ);
   assign mod_start   = (state_ff == ST_LOAD);
   assign mod_divisor = TTI_W'(rd_period) * TTI_W'(SUBFRAMES_PER_FRAME);
   assign pos_hit     = (mod_rem >= TTI_W'(start_ff))
                        && (mod_rem < (TTI_W'(start_ff) + TTI_W'(window_ff)));
   assign last_entry  = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   siwd_table #(
      .DEPTH(MAX_ENTRIES)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (count_ff[IDX_W-1:0]),
      .wr_period (req_period_frames),
      .wr_start  (wr_start),
      .rd_en     (rd_en),
      .rd_addr   (idx_ff),
      .rd_period (rd_period),
      .rd_start  (rd_start)
   );

   siwd_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (tti_ff),
      .divisor   (mod_divisor),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      window_in    = window_ff;
      tti_in       = tti_ff;
      start_in     = start_ff;
      rsp_valid_in = 1'b0;
      hit_in       = 1'b0;
      stored_in    = 1'b0;
      if (csr_wr_en) begin
         window_in = csr_wr_data;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  OP_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  OP_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (wr_en) begin
                        count_in  = count_ff + 1'b1;
                        stored_in = 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     tti_in = TTI_W'(req_frame_number) * TTI_W'(SUBFRAMES_PER_FRAME)
                              + TTI_W'(req_subframe);
                     idx_in = '0;
                     if ((count_ff == '0) || (req_subframe >= SF_W'(SUBFRAMES_PER_FRAME))) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            start_in = rd_start;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (mod_done) begin
               if (pos_hit || last_entry) begin
                  rsp_valid_in = 1'b1;
                  hit_in       = pos_hit;
                  state_in     = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      tti_ff   <= tti_in;
      start_ff <= start_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         window_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         stored_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         stored_ff    <= stored_in;
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_in_window    = hit_ff;
   assign rsp_entry_stored = stored_ff;

endmodule

`default_nettype wire

// ===== sv/siwd_checker.sv =====
// Port-level checks of si_window_detector and the bind that attaches them.
// Depends on siwd_pkg and si_window_detector_defines.svh.
`default_nettype none

`include "si_window_detector_defines.svh"

module siwd_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           start,
   input wire logic                           busy,
   input wire logic [siwd_pkg::OPCODE_W-1:0]  req_opcode,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_in_window,
   input wire logic                           rsp_entry_stored
);
   import siwd_pkg::*;

   // Every accepted transaction either answers at once or keeps the block busy.
   `SIWD_ASSERT_NEXT(a_accept_progress, start && !busy, rsp_valid || busy)
   // A result never coexists with an operation still in flight.
   `SIWD_ASSERT_NOW(a_rsp_not_busy, rsp_valid, !busy)
   // Result flags are only raised inside a valid result, and never both.
   `SIWD_ASSERT_NOW(a_flags_valid, rsp_in_window || rsp_entry_stored,
                    rsp_valid && !(rsp_in_window && rsp_entry_stored))
   // A stored flag only appears in the cycle after an accepted append.
   `SIWD_ASSERT_NEXT(a_stored_from_append, !(start && !busy && req_opcode == OP_APPEND),
                     !rsp_entry_stored)

endmodule

bind si_window_detector siwd_checker u_siwd_checker (.*);

`default_nettype wire
